// ===== rtl/bms_pkg.sv =====
// shared constants, types, melody rom and helpers for the buzzer melody sequencer
`timescale 1ns / 1ps

package bms_pkg;

	localparam int QUEUE_DEPTH  = 8;
	localparam int ROM_MELODIES = 9;
	localparam int ROM_NOTES    = 7;

	localparam int CMD_W     = 2;
	localparam int DELTA_W   = 16;
	localparam int SEL_W     = 3;
	localparam int TIME_W    = 32;
	localparam int HZ_W      = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int MEL_W     = 4;
	localparam int TIMER_W   = 16;
	localparam int MS_W      = 8;
	localparam int ROMLEN_W  = 3;
	localparam int NOTE_W    = $clog2(ROM_NOTES);
	localparam int LEN_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W     = (LEN_W > NOTE_W + 1) ? LEN_W : NOTE_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_PLAY     = 2'd1,
		CMD_ESCALATE = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUIET_UNTIL      = 3'd0,
		CFG_ANGRY_FROM       = 3'd1,
		CFG_FURIOUS_FROM     = 3'd2,
		CFG_ANNOYED_INTERVAL = 3'd3,
		CFG_ANGRY_INTERVAL   = 3'd4,
		CFG_FURIOUS_INTERVAL = 3'd5
	} cfg_idx_t;

	// highest avatar state that owns a melody (error)
	localparam logic [SEL_W-1:0] STATE_LAST = 3'd5;

	localparam logic [MEL_W-1:0] MEL_ANNOYED = 4'd6;
	localparam logic [MEL_W-1:0] MEL_ANGRY   = 4'd7;
	localparam logic [MEL_W-1:0] MEL_FURIOUS = 4'd8;

	localparam logic [CFG_W-1:0] RST_QUIET_UNTIL      = 16'd3000;
	localparam logic [CFG_W-1:0] RST_ANGRY_FROM       = 16'd6000;
	localparam logic [CFG_W-1:0] RST_FURIOUS_FROM     = 16'd10000;
	localparam logic [CFG_W-1:0] RST_ANNOYED_INTERVAL = 16'd4000;
	localparam logic [CFG_W-1:0] RST_ANGRY_INTERVAL   = 16'd2000;
	localparam logic [CFG_W-1:0] RST_FURIOUS_INTERVAL = 16'd800;

	localparam logic [HZ_W-1:0] ROM_HZ [ROM_MELODIES][ROM_NOTES] = '{
		'{10'd110, 10'd0, 10'd110, 10'd0, 10'd0,   10'd0, 10'd0},
		'{10'd330, 10'd0, 10'd370, 10'd0, 10'd415, 10'd0, 10'd0},
		'{10'd100, 10'd0, 10'd0,   10'd0, 10'd0,   10'd0, 10'd0},
		'{10'd440, 10'd0, 10'd554, 10'd0, 10'd659, 10'd0, 10'd880},
		'{10'd660, 10'd0, 10'd880, 10'd0, 10'd0,   10'd0, 10'd0},
		'{10'd880, 10'd0, 10'd440, 10'd0, 10'd220, 10'd0, 10'd110},
		'{10'd300, 10'd0, 10'd0,   10'd0, 10'd0,   10'd0, 10'd0},
		'{10'd500, 10'd0, 10'd600, 10'd0, 10'd0,   10'd0, 10'd0},
		'{10'd800, 10'd0, 10'd400, 10'd0, 10'd800, 10'd0, 10'd0}
	};

	localparam logic [MS_W-1:0] ROM_MS [ROM_MELODIES][ROM_NOTES] = '{
		'{8'd120, 8'd30, 8'd80, 8'd0,  8'd0,   8'd0,  8'd0},
		'{8'd50,  8'd20, 8'd50, 8'd20, 8'd60,  8'd0,  8'd0},
		'{8'd200, 8'd0,  8'd0,  8'd0,  8'd0,   8'd0,  8'd0},
		'{8'd80,  8'd20, 8'd80, 8'd20, 8'd80,  8'd20, 8'd200},
		'{8'd60,  8'd60, 8'd80, 8'd0,  8'd0,   8'd0,  8'd0},
		'{8'd80,  8'd20, 8'd80, 8'd20, 8'd120, 8'd20, 8'd200},
		'{8'd40,  8'd0,  8'd0,  8'd0,  8'd0,   8'd0,  8'd0},
		'{8'd50,  8'd30, 8'd60, 8'd0,  8'd0,   8'd0,  8'd0},
		'{8'd60,  8'd20, 8'd60, 8'd20, 8'd60,  8'd0,  8'd0}
	};

	localparam logic [ROMLEN_W-1:0] ROM_LEN [ROM_MELODIES] = '{
		3'd3, 3'd5, 3'd1, 3'd7, 3'd3, 3'd7, 3'd1, 3'd3, 3'd5
	};

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [DELTA_W-1:0] delta_ms;
		logic [SEL_W-1:0]   state_sel;
		logic [TIME_W-1:0]  state_time_ms;
	} bms_item_t;

	typedef struct packed {
		logic [HZ_W-1:0] tone_hz;
		logic            tone_on;
		logic            playing;
	} bms_res_t;

	typedef struct packed {
		logic [CFG_W-1:0] quiet_until_ms;
		logic [CFG_W-1:0] angry_from_ms;
		logic [CFG_W-1:0] furious_from_ms;
		logic [CFG_W-1:0] annoyed_interval_ms;
		logic [CFG_W-1:0] angry_interval_ms;
		logic [CFG_W-1:0] furious_interval_ms;
	} bms_cfg_t;

	// notes played for a melody, cut to the queue depth; unknown ids play nothing
	function automatic logic [LEN_W-1:0] mel_len(input logic [MEL_W-1:0] id);
		logic [LEN_W-1:0] n;
		n = '0;
		if (id < MEL_W'(ROM_MELODIES)) begin
			n = LEN_W'(ROM_LEN[id]);
			if (n > LEN_W'(QUEUE_DEPTH))
				n = LEN_W'(QUEUE_DEPTH);
		end
		return n;
	endfunction

endpackage

// ===== rtl/bms_if.sv =====
// valid/ready channel interfaces for sequencer commands and tone results
`timescale 1ns / 1ps

interface bms_item_if import bms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [DELTA_W-1:0] delta_ms;
	logic [SEL_W-1:0]   state_sel;
	logic [TIME_W-1:0]  state_time_ms;

	modport source (output valid, cmd, delta_ms, state_sel, state_time_ms, input ready);
	modport sink (input valid, cmd, delta_ms, state_sel, state_time_ms, output ready);
	modport monitor (input valid, ready, cmd, delta_ms, state_sel, state_time_ms);
endinterface

interface bms_result_if import bms_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [HZ_W-1:0] tone_hz;
	logic            tone_on;
	logic            playing;

	modport source (output valid, tone_hz, tone_on, playing, input ready);
	modport sink (input valid, tone_hz, tone_on, playing, output ready);
	modport monitor (input valid, ready, tone_hz, tone_on, playing);
endinterface

// ===== rtl/bms_cfg_regs.sv =====
// threshold and interval register file with reset defaults
`timescale 1ns / 1ps

module bms_cfg_regs import bms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output bms_cfg_t             cfg
);

	bms_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quiet_until_ms      <= RST_QUIET_UNTIL;
			cfg_q.angry_from_ms       <= RST_ANGRY_FROM;
			cfg_q.furious_from_ms     <= RST_FURIOUS_FROM;
			cfg_q.annoyed_interval_ms <= RST_ANNOYED_INTERVAL;
			cfg_q.angry_interval_ms   <= RST_ANGRY_INTERVAL;
			cfg_q.furious_interval_ms <= RST_FURIOUS_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_QUIET_UNTIL:      cfg_q.quiet_until_ms      <= cfg_wdata;
				CFG_ANGRY_FROM:       cfg_q.angry_from_ms       <= cfg_wdata;
				CFG_FURIOUS_FROM:     cfg_q.furious_from_ms     <= cfg_wdata;
				CFG_ANNOYED_INTERVAL: cfg_q.annoyed_interval_ms <= cfg_wdata;
				CFG_ANGRY_INTERVAL:   cfg_q.angry_interval_ms   <= cfg_wdata;
				CFG_FURIOUS_INTERVAL: cfg_q.furious_interval_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bms_core.sv =====
// melody state registers, next-state logic and tone lookup for one command
`timescale 1ns / 1ps

module bms_core import bms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  bms_item_t item,
	input  bms_cfg_t  cfg,
	output bms_res_t  res
);

	logic [MEL_W-1:0]   mel_q, mel_n;
	logic [NOTE_W-1:0]  idx_q, idx_n;
	logic [TIMER_W-1:0] timer_q, timer_n;
	logic               busy_q, busy_n;
	logic [TIME_W-1:0]  last_q, last_n;

	logic [LEN_W-1:0]   len;
	logic [TIMER_W:0]   sum;
	logic [TIMER_W-1:0] sat;
	logic [TIMER_W-1:0] cur_ms;
	logic [CMP_W-1:0]   idx_inc;
	logic [TIME_W-1:0]  diff;
	logic [CFG_W-1:0]   interval;
	logic [MEL_W-1:0]   esc_mel;
	logic               esc_go;
	logic [HZ_W-1:0]    hz;

	always_comb begin
		len     = mel_len(mel_q);
		sum     = {1'b0, timer_q} + {1'b0, item.delta_ms};
		sat     = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
		cur_ms  = (mel_q < MEL_W'(ROM_MELODIES) && idx_q < NOTE_W'(ROM_NOTES)) ?
			TIMER_W'(ROM_MS[mel_q][idx_q]) : '0;
		idx_inc = CMP_W'(idx_q) + CMP_W'(1);

		// phase tests in order annoyed, angry, furious
		if (item.state_time_ms < TIME_W'(cfg.angry_from_ms)) begin
			interval = cfg.annoyed_interval_ms;
			esc_mel  = MEL_ANNOYED;
		end else if (item.state_time_ms < TIME_W'(cfg.furious_from_ms)) begin
			interval = cfg.angry_interval_ms;
			esc_mel  = MEL_ANGRY;
		end else begin
			interval = cfg.furious_interval_ms;
			esc_mel  = MEL_FURIOUS;
		end
		// elapsed time wraps modulo 2^32
		diff   = item.state_time_ms - last_q;
		esc_go = !busy_q && item.state_time_ms >= TIME_W'(cfg.quiet_until_ms) &&
			diff >= TIME_W'(interval);

		mel_n   = mel_q;
		idx_n   = idx_q;
		timer_n = timer_q;
		busy_n  = busy_q;
		last_n  = last_q;

		case (item.cmd)
			CMD_TICK: begin
				if (busy_q && len != '0 && idx_q < NOTE_W'(ROM_NOTES)) begin
					timer_n = sat;
					if (sat >= cur_ms) begin
						if (idx_inc < CMP_W'(len)) begin
							idx_n   = idx_inc[NOTE_W-1:0];
							timer_n = '0;
						end else begin
							busy_n = 1'b0;
							idx_n  = '0;
						end
					end
				end
			end
			CMD_PLAY: begin
				busy_n = 1'b0;
				idx_n  = '0;
				if (item.state_sel <= STATE_LAST) begin
					mel_n   = MEL_W'(item.state_sel);
					timer_n = '0;
					busy_n  = mel_len(MEL_W'(item.state_sel)) != '0;
				end
			end
			CMD_ESCALATE: begin
				if (esc_go) begin
					last_n  = item.state_time_ms;
					mel_n   = esc_mel;
					idx_n   = '0;
					timer_n = '0;
					busy_n  = mel_len(esc_mel) != '0;
				end
			end
			default: ;
		endcase

		hz = '0;
		if (busy_n && mel_n < MEL_W'(ROM_MELODIES) && idx_n < NOTE_W'(ROM_NOTES))
			hz = ROM_HZ[mel_n][idx_n];

		res.tone_hz = hz;
		res.tone_on = hz != '0;
		res.playing = busy_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mel_q   <= '0;
			idx_q   <= '0;
			timer_q <= '0;
			busy_q  <= 1'b0;
			last_q  <= '0;
		end else if (fire) begin
			mel_q   <= mel_n;
			idx_q   <= idx_n;
			timer_q <= timer_n;
			busy_q  <= busy_n;
			last_q  <= last_n;
		end
	end

endmodule

// ===== rtl/buzzer_melody_sequencer.sv =====
// buzzer melody sequencer top level: input register, core update, result register
//
//   channel   dir   transfer when          payload
//   item      in    item.valid & ready     cmd, delta_ms, state_sel, state_time_ms
//   result    out   result.valid & ready   tone_hz, tone_on, playing
//   cfg       in    cfg_we high            cfg_idx, cfg_wdata
//
// one command per cycle while results are taken; its result passes the input register,
// then state update and rom lookup into the result register
// reset clears the melody state and loads the default thresholds and intervals
// a stalled result holds the result register; the input register keeps taking
// commands until it too is full, then item.ready drops
`timescale 1ns / 1ps

module buzzer_melody_sequencer import bms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bms_item_if.sink             item,
	bms_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	bms_cfg_t  cfg;
	bms_item_t item_s1;
	logic      valid_s1;
	bms_res_t  res_comb;
	bms_res_t  res_s2;
	logic      valid_s2;
	logic      adv;
	logic      fire;
	logic      take;

	assign adv        = !valid_s2 || result.ready;
	assign fire       = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;
	assign take       = item.valid && item.ready;

	bms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bms_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd           <= item.cmd;
			item_s1.delta_ms      <= item.delta_ms;
			item_s1.state_sel     <= item.state_sel;
			item_s1.state_time_ms <= item.state_time_ms;
		end
		if (fire)
			res_s2 <= res_comb;
	end

	assign result.valid   = valid_s2;
	assign result.tone_hz = res_s2.tone_hz;
	assign result.tone_on = res_s2.tone_on;
	assign result.playing = res_s2.playing;

endmodule

// ===== rtl/bms_checker.sv =====
// port-level checks for the buzzer melody sequencer, bound to the top level
`timescale 1ns / 1ps

module bms_checker import bms_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	bms_item_if.sink     item,
	bms_result_if.source result
);

	// a sounding tone only ever comes from a running melody
	a_tone_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.tone_on |-> result.playing)
		else $error("tone on while no melody plays");

	a_tone_hz_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.tone_on |-> result.tone_hz != '0)
		else $error("tone on with zero frequency");

	a_silent_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.playing |-> result.tone_hz == '0 && !result.tone_on)
		else $error("tone while idle");

	// nothing is offered without a command having been taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(item.valid && item.ready, 2))
		else $error("result without a command transfer");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.tone_hz)
			&& $stable(result.tone_on) && $stable(result.playing))
		else $error("stalled result changed");

endmodule

bind buzzer_melody_sequencer bms_checker u_bms_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the buzzer melody sequencer
`timescale 1ns / 1ps

module testbench;
	import bms_pkg::*;

	localparam int TUNES      = 9;
	localparam int NOTE_SLOTS = 7;
	localparam int DEPTH      = 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int unsigned TUNE_HZ [TUNES][NOTE_SLOTS] = '{
		'{110, 0, 110, 0, 0, 0, 0},
		'{330, 0, 370, 0, 415, 0, 0},
		'{100, 0, 0, 0, 0, 0, 0},
		'{440, 0, 554, 0, 659, 0, 880},
		'{660, 0, 880, 0, 0, 0, 0},
		'{880, 0, 440, 0, 220, 0, 110},
		'{300, 0, 0, 0, 0, 0, 0},
		'{500, 0, 600, 0, 0, 0, 0},
		'{800, 0, 400, 0, 800, 0, 0}
	};
	localparam int unsigned TUNE_MS [TUNES][NOTE_SLOTS] = '{
		'{120, 30, 80, 0, 0, 0, 0},
		'{50, 20, 50, 20, 60, 0, 0},
		'{200, 0, 0, 0, 0, 0, 0},
		'{80, 20, 80, 20, 80, 20, 200},
		'{60, 60, 80, 0, 0, 0, 0},
		'{80, 20, 80, 20, 120, 20, 200},
		'{40, 0, 0, 0, 0, 0, 0},
		'{50, 30, 60, 0, 0, 0, 0},
		'{60, 20, 60, 20, 60, 0, 0}
	};
	localparam int unsigned TUNE_NOTES [TUNES] = '{3, 5, 1, 7, 3, 7, 1, 3, 5};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	bms_item_if item_ch ();
	bms_result_if tone_ch ();

	buzzer_melody_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (tone_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// sequencer copy: thresholds, intervals and melody position
	logic [CFG_W-1:0] limits [6];
	logic [MEL_W-1:0] tune_id;
	int unsigned note_pos;
	logic [15:0] note_ms;
	logic sounding;
	logic [31:0] last_beep;

	bms_item_t pending_cmds [$];
	bms_res_t tone_expect [$];
	bms_item_t cur_cmd;
	logic [31:0] wait_ms;
	int unsigned tx_gap, tx_steady, rx_gap, rx_steady, hold_left;
	int unsigned tones_seen;
	int unsigned fail_count;

	always #1 clk = ~clk;

	function automatic int unsigned tune_len(input logic [MEL_W-1:0] id);
		if (id >= TUNES)
			return 0;
		return (TUNE_NOTES[id] > DEPTH) ? DEPTH : TUNE_NOTES[id];
	endfunction

	task automatic start_tune(input logic [MEL_W-1:0] id);
		tune_id = id;
		note_pos = 0;
		note_ms = '0;
		sounding = tune_len(id) != 0;
	endtask

	task automatic advance_sequencer(input bms_item_t it, output bms_res_t res);
		logic [16:0] sum;
		logic [CFG_W-1:0] spacing;
		logic [MEL_W-1:0] pattern;
		int unsigned hz;
		case (it.cmd)
		CMD_TICK: begin
			if (sounding && tune_len(tune_id) != 0 && note_pos < NOTE_SLOTS) begin
				sum = {1'b0, note_ms} + it.delta_ms;
				note_ms = sum[16] ? 16'hFFFF : sum[15:0];
				if (note_ms >= TUNE_MS[tune_id][note_pos]) begin
					note_pos++;
					if (note_pos < tune_len(tune_id)) begin
						note_ms = '0;
					end else begin
						sounding = 1'b0;
						note_pos = 0;
					end
				end
			end
		end
		CMD_PLAY: begin
			sounding = 1'b0;
			note_pos = 0;
			if (it.state_sel <= STATE_LAST)
				start_tune({1'b0, it.state_sel});
		end
		CMD_ESCALATE: begin
			if (!sounding && it.state_time_ms >= limits[CFG_QUIET_UNTIL]) begin
				if (it.state_time_ms < limits[CFG_ANGRY_FROM]) begin
					spacing = limits[CFG_ANNOYED_INTERVAL];
					pattern = MEL_ANNOYED;
				end else if (it.state_time_ms < limits[CFG_FURIOUS_FROM]) begin
					spacing = limits[CFG_ANGRY_INTERVAL];
					pattern = MEL_ANGRY;
				end else begin
					spacing = limits[CFG_FURIOUS_INTERVAL];
					pattern = MEL_FURIOUS;
				end
				// elapsed time wraps at 32 bits
				if (32'(it.state_time_ms - last_beep) >= 32'(spacing)) begin
					last_beep = it.state_time_ms;
					start_tune(pattern);
				end
			end
		end
		default: ;
		endcase
		hz = 0;
		if (sounding && tune_id < TUNES && note_pos < NOTE_SLOTS)
			hz = TUNE_HZ[tune_id][note_pos];
		res.tone_hz = hz[HZ_W-1:0];
		res.tone_on = hz != 0;
		res.playing = sounding;
	endtask

	// arg is delta for a tick, state for a play, time for an escalation
	task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [31:0] arg);
		bms_item_t it;
		it.cmd = c;
		it.delta_ms = DELTA_W'($urandom_range(0, 65535));
		it.state_sel = SEL_W'($urandom_range(0, 7));
		it.state_time_ms = $urandom();
		case (c)
		CMD_TICK: it.delta_ms = arg[DELTA_W-1:0];
		CMD_PLAY: it.state_sel = arg[SEL_W-1:0];
		CMD_ESCALATE: it.state_time_ms = arg;
		default: ;
		endcase
		pending_cmds.push_back(it);
	endtask

	function automatic logic [DELTA_W-1:0] tick_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 85)
			return DELTA_W'($urandom_range(1, 210));
		return DELTA_W'($urandom_range(0, 65535));
	endfunction

	task automatic queue_random_burst();
		int unsigned r, n;
		logic [31:0] t;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			case ($urandom_range(0, 4))
			0, 1: begin
				wait_ms += $urandom_range(0, 1200);
				t = wait_ms;
			end
			// land just around one of the thresholds
			2: t = 32'(limits[$urandom_range(0, 2)]) + $urandom_range(0, 2500) - 32'd20;
			3: begin
				wait_ms = $urandom_range(0, 100);
				t = wait_ms;
			end
			default: t = $urandom();
			endcase
			queue_cmd(CMD_ESCALATE, t);
			n = $urandom_range(0, 8);
			repeat (n) queue_cmd(CMD_TICK, 32'(tick_delta()));
		end else if (r < 85) begin
			if ($urandom_range(0, 19) == 0)
				queue_cmd(CMD_PLAY, $urandom_range(6, 7));
			else
				queue_cmd(CMD_PLAY, $urandom_range(0, 5));
			n = $urandom_range(1, 10);
			repeat (n) queue_cmd(CMD_TICK, 32'(tick_delta()));
		end else begin
			queue_cmd(CMD_W'($urandom_range(0, 3)), $urandom());
		end
	endtask

	// mostly short gaps, a few long ones, now and then a run with none
	task automatic pick_idle(inout int unsigned steady, output int unsigned gap);
		int unsigned r;
		r = $urandom_range(0, 99);
		gap = 0;
		if (steady != 0)
			steady--;
		else if (r < 3)
			steady = $urandom_range(20, 60);
		else if (r < 45)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 96)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 45);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || item_ch.valid || tone_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		limits[idx] = val;
	endtask

	task automatic load_limits(input int unsigned quiet, angry, furious,
			annoyed_gap, angry_gap, furious_gap);
		repeat (4) @(posedge clk);
		write_limit(CFG_QUIET_UNTIL, CFG_W'(quiet));
		write_limit(CFG_ANGRY_FROM, CFG_W'(angry));
		write_limit(CFG_FURIOUS_FROM, CFG_W'(furious));
		write_limit(CFG_ANNOYED_INTERVAL, CFG_W'(annoyed_gap));
		write_limit(CFG_ANGRY_INTERVAL, CFG_W'(angry_gap));
		write_limit(CFG_FURIOUS_INTERVAL, CFG_W'(furious_gap));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin : cmd_driver
		bms_res_t want;
		logic offer;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			offer = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				advance_sequencer(cur_cmd, want);
				tone_expect.push_back(want);
				offer = 1'b0;
			end
			if (!offer) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (pending_cmds.size() != 0) begin
					cur_cmd = pending_cmds.pop_front();
					item_ch.cmd <= cur_cmd.cmd;
					item_ch.delta_ms <= cur_cmd.delta_ms;
					item_ch.state_sel <= cur_cmd.state_sel;
					item_ch.state_time_ms <= cur_cmd.state_time_ms;
					offer = 1'b1;
					pick_idle(tx_steady, tx_gap);
				end
			end
			item_ch.valid <= offer;
		end
	end

	always @(posedge clk) begin : tone_monitor
		bms_res_t got, want;
		if (!arst_n) begin
			tone_ch.ready <= 1'b0;
		end else begin
			if (tone_ch.valid && tone_ch.ready) begin
				got.tone_hz = tone_ch.tone_hz;
				got.tone_on = tone_ch.tone_on;
				got.playing = tone_ch.playing;
				tones_seen++;
				if (tone_expect.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected tone transfer: hz %0d on %0b playing %0b",
							got.tone_hz, got.tone_on, got.playing);
				end else begin
					want = tone_expect.pop_front();
					if (got.tone_hz !== want.tone_hz || got.tone_on !== want.tone_on ||
							got.playing !== want.playing) begin
						fail_count++;
						if (fail_count <= 10)
							$display("tone %0d wrong: expected hz %0d on %0b playing %0b, %s %0d %0b %0b",
								tones_seen, want.tone_hz, want.tone_on, want.playing,
								"got", got.tone_hz, got.tone_on, got.playing);
					end
				end
				// long stalls so the input side backs up
				if (tones_seen == 100 || tones_seen == 400 || tones_seen == 800)
					hold_left = $urandom_range(60, 90);
				else
					pick_idle(rx_steady, rx_gap);
			end
			if (hold_left != 0) begin
				hold_left--;
				tone_ch.ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				tone_ch.ready <= 1'b0;
			end else begin
				tone_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#2000000;
		$display("buzzer_melody_sequencer: mismatch");
		$finish;
	end

	initial begin : stimulus
		int p;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = '0;
		item_ch.delta_ms = '0;
		item_ch.state_sel = '0;
		item_ch.state_time_ms = '0;
		tone_ch.ready = 1'b0;
		limits = '{16'd3000, 16'd6000, 16'd10000, 16'd4000, 16'd2000, 16'd800};
		tune_id = '0;
		note_pos = 0;
		note_ms = '0;
		sounding = 1'b0;
		last_beep = '0;
		wait_ms = '0;
		tx_gap = 0;
		tx_steady = 0;
		rx_gap = 0;
		rx_steady = 0;
		hold_left = 0;
		tones_seen = 0;
		fail_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset thresholds
		queue_cmd(CMD_UNUSED, $urandom());
		queue_cmd(CMD_TICK, 0);
		queue_cmd(CMD_PLAY, 3);
		queue_cmd(CMD_TICK, 79);
		queue_cmd(CMD_TICK, 1);
		queue_cmd(CMD_TICK, 32'hFFFF);
		queue_cmd(CMD_TICK, 32'hFFFF);
		queue_cmd(CMD_TICK, 0);
		queue_cmd(CMD_PLAY, 6);
		queue_cmd(CMD_PLAY, 7);
		queue_cmd(CMD_TICK, 32'hFFFF);
		queue_cmd(CMD_PLAY, 0);
		queue_cmd(CMD_PLAY, 1);
		queue_cmd(CMD_PLAY, 2);
		queue_cmd(CMD_PLAY, 4);
		queue_cmd(CMD_PLAY, 5);
		queue_cmd(CMD_PLAY, 6);
		queue_cmd(CMD_ESCALATE, 2999);
		queue_cmd(CMD_ESCALATE, 3000);
		queue_cmd(CMD_ESCALATE, 4000);
		queue_cmd(CMD_ESCALATE, 20000);
		queue_cmd(CMD_TICK, 32'hFFFF);
		queue_cmd(CMD_ESCALATE, 7000);
		repeat (3) queue_cmd(CMD_TICK, 32'hFFFF);
		queue_cmd(CMD_ESCALATE, 32'hFFFF_FFFF);
		queue_cmd(CMD_ESCALATE, 32'hFFFF_FFFF);
		queue_cmd(CMD_UNUSED, $urandom());
		while (pending_cmds.size() < 175)
			queue_random_burst();
		drain();

		for (p = 1; p <= 6; p++) begin
			case (p)
			1: load_limits(0, 0, 0, 0, 0, 0);
			2: load_limits(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
			// thresholds out of order
			3: load_limits($urandom_range(20000, 40000), $urandom_range(5000, 15000),
				$urandom_range(0, 5000), $urandom_range(0, 3000),
				$urandom_range(0, 3000), $urandom_range(0, 3000));
			4: load_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
			5: load_limits($urandom_range(0, 500), $urandom_range(500, 1500),
				$urandom_range(1500, 3000), $urandom_range(0, 300),
				$urandom_range(0, 300), $urandom_range(0, 300));
			default: load_limits(3000, 6000, 10000, 4000, 2000, 800);
			endcase
			wait_ms = '0;
			while (pending_cmds.size() < 150)
				queue_random_burst();
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && tone_expect.size() == 0)
			$display("buzzer_melody_sequencer: match");
		else
			$display("buzzer_melody_sequencer: mismatch");
		$finish;
	end

endmodule

// ===== buzzer_melody_sequencer.f =====
rtl/bms_pkg.sv
rtl/bms_if.sv
rtl/bms_cfg_regs.sv
rtl/bms_core.sv
rtl/buzzer_melody_sequencer.sv
rtl/bms_checker.sv
tb/testbench.sv
